FILE: hdl/dag_pkg.sv
// ----------------------------------------------------------------------------
// dag_pkg
// Shared widths, codes, types and table builders for the distance
// attenuation gain pipeline.
// ----------------------------------------------------------------------------
package dag_pkg;

   // field and datapath widths
   localparam int DIST_WIDTH      = 24;
   localparam int LOG_TABLE_DEPTH = 256;
   localparam int ROLL_W          = 16;
   localparam int GAIN_W          = 16;
   localparam int LOG_IDX_W       = $clog2(LOG_TABLE_DEPTH);
   localparam int EXPO_W          = $clog2(DIST_WIDTH);
   localparam int LOG_W           = EXPO_W + 16;
   localparam int EXP_ROM_W       = 31;
   localparam int T_W             = ROLL_W + LOG_W - 8;

   // divider geometry
   localparam int Q_BITS    = 15;
   localparam int DIV_NUM_W = ROLL_W + DIST_WIDTH + 7;
   localparam int DIV_DEN_W = ROLL_W + DIST_WIDTH + 1;
   localparam int DIV_LAT   = Q_BITS + 1;
   localparam int EXP_LAT   = 2;

   // port widths
   localparam int REQ_DATA_W  = ((DIST_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((GAIN_W + 1 + 7) / 8) * 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [GAIN_W-1:0] ONE_Q15 = GAIN_W'(32768);

   typedef enum logic [1:0] {
      CURVE_NONE,
      CURVE_LINEAR,
      CURVE_INVERSE,
      CURVE_EXPONENTIAL
   } curve_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_DISTANCE,
      CSR_MAX_DISTANCE,
      CSR_ROLLOFF,
      CSR_CURVE_MODE
   } csr_index_type;

   // per-item flags that ride alongside the dividers
   typedef struct packed {
      logic      valid;
      logic      bad;
      curve_type mode;
      logic      eq_ref;
      logic      ref_zero;
      logic      span_zero;
      logic      den_zero;
   } side_type;

   typedef logic [LOG_TABLE_DEPTH-1:0][15:0]          log_tab_type;
   typedef logic [LOG_TABLE_DEPTH-1:0][EXP_ROM_W-1:0] exp_tab_type;

   // q16 log2 of a q30 value in [1, 2] by repeated squaring
   function automatic logic [16:0] frac_log2(input logic [63:0] z_in);
      logic [63:0] z;
      logic [16:0] acc;
      z   = z_in;
      acc = '0;
      if (z >= (64'd1 << 31)) begin
         return 17'd65536;
      end
      for (int i = 15; i >= 0; i--) begin
         z = (z * z) >> 30;
         if (z >= (64'd1 << 31)) begin
            z      = z >> 1;
            acc[i] = 1'b1;
         end
      end
      return acc;
   endfunction

   // mantissa log table
   function automatic log_tab_type build_log_tab();
      log_tab_type tab;
      logic [63:0] z;
      logic [16:0] v;
      for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
         z      = ((64'(LOG_TABLE_DEPTH) + 64'(k)) << 30) / LOG_TABLE_DEPTH;
         v      = frac_log2(z);
         tab[k] = v[15:0];
      end
      return tab;
   endfunction

   // q30 power table, inverse of the log table by binary search
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] lim;
      for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
         lo  = 64'd1 << 29;
         hi  = 64'd1 << 30;
         lim = (64'(LOG_TABLE_DEPTH) - 64'(k)) * 64'd65536;
         for (int it = 0; it < 32; it++) begin
            if (lo < hi) begin
               mid = lo + ((hi - lo + 64'd1) >> 1);
               if (64'(frac_log2(mid << 1)) * 64'(LOG_TABLE_DEPTH) <= lim) begin
                  lo = mid;
               end else begin
                  hi = mid - 64'd1;
               end
            end
         end
         tab[k] = lo[EXP_ROM_W-1:0];
      end
      return tab;
   endfunction

endpackage

FILE: hdl/dag_div.sv
// ----------------------------------------------------------------------------
// dag_div
// Pipelined saturating restoring divider, one quotient bit per stage.
// Quotients at or above 1.0 come out as exactly 1.0 in q1.15.
// ----------------------------------------------------------------------------
module dag_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [dag_pkg::DIV_NUM_W-1:0] num_in,
   input  logic [dag_pkg::DIV_DEN_W-1:0] den_in,
   output logic [dag_pkg::GAIN_W-1:0]    quo_out
);
   import dag_pkg::*;

   localparam int CMP_W = DIV_DEN_W + Q_BITS;

   logic [DIV_NUM_W-1:0] rem_ff [DIV_LAT];
   logic [DIV_DEN_W-1:0] den_ff [DIV_LAT];
   logic [Q_BITS-1:0]    quo_ff [DIV_LAT];
   logic                 sat_ff [DIV_LAT];

   // saturation check against the full quotient range
   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff[0] <= CMP_W'(num_in) >= {den_in, {Q_BITS{1'b0}}};
         rem_ff[0] <= num_in;
         den_ff[0] <= den_in;
         quo_ff[0] <= '0;
      end
   end

   // one trial subtraction per stage, msb first
   for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
      localparam int B = Q_BITS - k;
      logic [CMP_W-1:0] trial;
      logic             take;

      assign trial = CMP_W'(den_ff[k-1]) << B;
      assign take  = !sat_ff[k-1] && (CMP_W'(rem_ff[k-1]) >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? rem_ff[k-1] - DIV_NUM_W'(trial) : rem_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            quo_ff[k] <= quo_ff[k-1] | (take ? (Q_BITS'(1) << B) : Q_BITS'(0));
         end
      end
   end

   assign quo_out = sat_ff[DIV_LAT-1] ? ONE_Q15 : GAIN_W'(quo_ff[DIV_LAT-1]);

endmodule

FILE: hdl/dag_log.sv
// ----------------------------------------------------------------------------
// dag_log
// Two-stage q16 log2: leading-one search, then normalize and table lookup.
// ----------------------------------------------------------------------------
module dag_log (
   input  logic                           clock,
   input  logic                           en,
   input  logic [dag_pkg::DIST_WIDTH-1:0] value_in,
   output logic [dag_pkg::LOG_W-1:0]      log_out
);
   import dag_pkg::*;

   localparam log_tab_type LOG_TAB = build_log_tab();
   localparam int          EXT_W   = DIST_WIDTH - 1 + LOG_IDX_W;

   logic [DIST_WIDTH-1:0] value_ff;
   logic [EXPO_W-1:0]     msb_in;
   logic [EXPO_W-1:0]     msb_ff;
   logic [DIST_WIDTH-1:0] norm;
   logic [EXT_W-1:0]      frac_ext;
   logic [LOG_IDX_W-1:0]  idx;
   logic [LOG_W-1:0]      log_ff;

   // leading one position
   always_comb begin
      msb_in = '0;
      for (int i = 0; i < DIST_WIDTH; i++) begin
         if (value_in[i]) begin
            msb_in = EXPO_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
         msb_ff   <= msb_in;
      end
   end

   // mantissa bits below the leading one select the table entry
   assign norm     = value_ff << (EXPO_W'(DIST_WIDTH - 1) - msb_ff);
   assign frac_ext = {norm[DIST_WIDTH-2:0], {LOG_IDX_W{1'b0}}};
   assign idx      = frac_ext[EXT_W-1 -: LOG_IDX_W];

   always_ff @(posedge clock) begin
      if (en) begin
         log_ff <= {msb_ff, LOG_TAB[idx]};
      end
   end

   assign log_out = log_ff;

endmodule

FILE: hdl/dag_exp.sv
// ----------------------------------------------------------------------------
// dag_exp
// Exponential curve base: scales the log difference by the rolloff, then
// takes 2^-t from the power table with a rounded right shift.
// ----------------------------------------------------------------------------
module dag_exp (
   input  logic                       clock,
   input  logic                       en,
   input  logic [dag_pkg::LOG_W-1:0]  log_d_in,
   input  logic [dag_pkg::LOG_W-1:0]  log_r_in,
   input  logic [dag_pkg::ROLL_W-1:0] rolloff_in,
   output logic [dag_pkg::GAIN_W-1:0] base_out
);
   import dag_pkg::*;

   localparam exp_tab_type EXP_TAB   = build_exp_tab();
   localparam int          PROD_W    = ROLL_W + LOG_W;
   localparam int          N_W       = T_W - 16;
   localparam int          SHIFT_W   = 6;
   localparam int          SUM_W     = 46;
   localparam int          ZERO_EXPO = 30;

   logic [LOG_W-1:0]     diff;
   logic [PROD_W-1:0]    prod;
   logic [T_W-1:0]       t_ff;
   logic [N_W-1:0]       expo_int;
   logic [LOG_IDX_W-1:0] fidx;
   logic [SHIFT_W-1:0]   shift;
   logic [SUM_W-1:0]     sum;
   logic [GAIN_W-1:0]    base_in;
   logic [GAIN_W-1:0]    base_ff;

   // scaled exponent in q16
   assign diff = log_d_in - log_r_in;
   assign prod = PROD_W'(rolloff_in) * PROD_W'(diff);

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= prod[PROD_W-1:8];
      end
   end

   // table value shifted down by the integer part, rounded half up
   assign expo_int = t_ff[T_W-1:16];
   assign fidx     = t_ff[15 -: LOG_IDX_W];
   assign shift    = SHIFT_W'(expo_int) + SHIFT_W'(15);
   assign sum      = SUM_W'(EXP_TAB[fidx]) + (SUM_W'(1) << (shift - SHIFT_W'(1)));

   always_comb begin
      if (expo_int >= N_W'(ZERO_EXPO)) begin
         base_in = '0;
      end else begin
         base_in = GAIN_W'(sum >> shift);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff <= base_in;
      end
   end

   assign base_out = base_ff;

endmodule

FILE: hdl/distance_attenuation_gain.sv
// A result reaches rsp through stages 1 to 3, the divider stages, the final register and the output register.
// Throughput: one distance per cycle, limited by nothing but the output side.
// The long pole is the 16-stage divider (saturation check plus 15 bit steps).
// Reset clears all valid bits and the skid stage and loads the register
// defaults; the lookup tables are constants and need no fill.
// ----------------------------------------------------------------------------
// distance_attenuation_gain
// Maps a source distance to a q1.15 gain using a none, linear, inverse or
// exponential curve; the inverse and exponential curves fade over the last tenth of the range.
// ----------------------------------------------------------------------------
module distance_attenuation_gain (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [DIST_WIDTH-1:0] source_distance
   input  logic [dag_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] proximity_gain, [16] bad_config
   output logic [dag_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [dag_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dag_pkg::DIST_WIDTH-1:0]  csr_wdata
);
   import dag_pkg::*;

   localparam logic [DIST_WIDTH-1:0] REF_RESET  = DIST_WIDTH'(25600);
   localparam logic [DIST_WIDTH-1:0] MAX_RESET  = DIST_WIDTH'(25600);
   localparam logic [ROLL_W-1:0]     ROLL_RESET = ROLL_W'(256);
   localparam int                    PROD_W     = ROLL_W + DIST_WIDTH;
   localparam int                    FADE_W     = DIST_WIDTH + 4 + Q_BITS;
   localparam int                    EB_DEPTH   = DIV_LAT - EXP_LAT;
   localparam int                    MULT_W     = 2 * GAIN_W;
   localparam int                    PAD_W      = RSP_DATA_W - GAIN_W - 1;

   // configuration registers
   logic [DIST_WIDTH-1:0] ref_ff;
   logic [DIST_WIDTH-1:0] max_ff;
   logic [ROLL_W-1:0]     rolloff_ff;
   curve_type             mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff     <= REF_RESET;
         max_ff     <= MAX_RESET;
         rolloff_ff <= ROLL_RESET;
         mode_ff    <= CURVE_LINEAR;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_REF_DISTANCE: ref_ff     <= csr_wdata;
            CSR_MAX_DISTANCE: max_ff     <= csr_wdata;
            CSR_ROLLOFF:      rolloff_ff <= csr_wdata[ROLL_W-1:0];
            CSR_CURVE_MODE:   mode_ff    <= curve_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless the skid stage is holding a result
   logic en;
   logic skid_valid_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // stage 1: clamp distance into the reference..maximum range
   logic [DIST_WIDTH-1:0] dist_raw;
   logic [DIST_WIDTH-1:0] dist_c_in;
   logic [DIST_WIDTH-1:0] dist_s1_ff;
   logic                  valid_s1_ff;

   assign dist_raw  = req_tdata[DIST_WIDTH-1:0];
   assign dist_c_in = (dist_raw < ref_ff) ? ref_ff :
                      ((dist_raw > max_ff) ? max_ff : dist_raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
      end else if (en) begin
         valid_s1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_s1_ff <= dist_c_in;
      end
   end

   // stage 2: rolloff product and fade numerator
   logic [DIST_WIDTH-1:0]   d_off;
   logic [DIST_WIDTH-1:0]   m_off;
   logic [DIST_WIDTH+3:0]   m_off_x10;
   logic [PROD_W-1:0]       prod_s2_ff;
   logic [FADE_W-1:0]       fade_num_s2_ff;
   logic                    eq_ref_s2_ff;
   logic                    valid_s2_ff;

   assign d_off     = dist_s1_ff - ref_ff;
   assign m_off     = max_ff - dist_s1_ff;
   assign m_off_x10 = ((DIST_WIDTH+4)'(m_off) << 3) + ((DIST_WIDTH+4)'(m_off) << 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s2_ff <= 1'b0;
      end else if (en) begin
         valid_s2_ff <= valid_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_s2_ff     <= PROD_W'(rolloff_ff) * PROD_W'(d_off);
         fade_num_s2_ff <= {m_off_x10, {Q_BITS{1'b0}}};
         eq_ref_s2_ff   <= (dist_s1_ff == ref_ff);
      end
   end

   // stage 3: divider operands for the fade and the selected curve
   logic [DIV_NUM_W-1:0] num_b_in;
   logic [DIV_DEN_W-1:0] den_b_in;
   logic [DIV_NUM_W-1:0] num_a_ff;
   logic [DIV_DEN_W-1:0] den_a_ff;
   logic [DIV_NUM_W-1:0] num_b_ff;
   logic [DIV_DEN_W-1:0] den_b_ff;
   side_type             side_in;
   side_type             side_ff [DIV_LAT+1];

   always_comb begin
      if (mode_ff == CURVE_LINEAR) begin
         num_b_in = DIV_NUM_W'(prod_s2_ff) << (Q_BITS - 8);
         den_b_in = DIV_DEN_W'(max_ff - ref_ff);
      end else begin
         num_b_in = DIV_NUM_W'(ref_ff) << (Q_BITS + 8);
         den_b_in = (DIV_DEN_W'(ref_ff) << 8) + DIV_DEN_W'(prod_s2_ff);
      end
      side_in.valid     = valid_s2_ff;
      side_in.bad       = (ref_ff > max_ff);
      side_in.mode      = mode_ff;
      side_in.eq_ref    = eq_ref_s2_ff;
      side_in.ref_zero  = (ref_ff == '0);
      side_in.span_zero = (ref_ff == max_ff);
      side_in.den_zero  = (den_b_in == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_a_ff <= DIV_NUM_W'(fade_num_s2_ff);
         den_a_ff <= DIV_DEN_W'(max_ff);
         num_b_ff <= num_b_in;
         den_b_ff <= den_b_in;
      end
   end

   // flags follow the items through the divider depth
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_LAT; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k <= DIV_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // fade and curve dividers
   logic [GAIN_W-1:0] fade_q;
   logic [GAIN_W-1:0] curve_q;

   dag_div u_div_fade (
      .clock   (clock),
      .en      (en),
      .num_in  (num_a_ff),
      .den_in  (den_a_ff),
      .quo_out (fade_q)
   );

   dag_div u_div_curve (
      .clock   (clock),
      .en      (en),
      .num_in  (num_b_ff),
      .den_in  (den_b_ff),
      .quo_out (curve_q)
   );

   // log2 of distance and reference, then the power curve
   logic [LOG_W-1:0]  log_d;
   logic [LOG_W-1:0]  log_r;
   logic [GAIN_W-1:0] exp_base;
   logic [GAIN_W-1:0] ebase_ff [EB_DEPTH];

   dag_log u_log_dist (
      .clock    (clock),
      .en       (en),
      .value_in (dist_s1_ff),
      .log_out  (log_d)
   );

   dag_log u_log_ref (
      .clock    (clock),
      .en       (en),
      .value_in (ref_ff),
      .log_out  (log_r)
   );

   dag_exp u_exp (
      .clock      (clock),
      .en         (en),
      .log_d_in   (log_d),
      .log_r_in   (log_r),
      .rolloff_in (rolloff_ff),
      .base_out   (exp_base)
   );

   // delay the power result to line up with the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         ebase_ff[0] <= exp_base;
         for (int j = 1; j < EB_DEPTH; j++) begin
            ebase_ff[j] <= ebase_ff[j-1];
         end
      end
   end

   // curve selection and fade multiply
   side_type          side_last;
   logic              use_mult_in;
   logic [GAIN_W-1:0] base_in;
   logic [GAIN_W-1:0] direct_in;
   logic              fin_valid_ff;
   logic              fin_bad_ff;
   logic              fin_use_ff;
   logic [GAIN_W-1:0] fin_direct_ff;
   logic [MULT_W-1:0] fin_prod_ff;

   assign side_last = side_ff[DIV_LAT];

   always_comb begin
      use_mult_in = 1'b0;
      base_in     = ONE_Q15;
      direct_in   = ONE_Q15;
      if (!side_last.bad) begin
         case (side_last.mode)
            CURVE_LINEAR: begin
               direct_in = side_last.span_zero ? ONE_Q15 : ONE_Q15 - curve_q;
            end
            CURVE_INVERSE: begin
               if (!side_last.den_zero) begin
                  use_mult_in = 1'b1;
                  base_in     = curve_q;
               end
            end
            CURVE_EXPONENTIAL: begin
               if (side_last.eq_ref) begin
                  use_mult_in = 1'b1;
                  base_in     = ONE_Q15;
               end else if (side_last.ref_zero) begin
                  direct_in = '0;
               end else begin
                  use_mult_in = 1'b1;
                  base_in     = ebase_ff[EB_DEPTH-1];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= side_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_bad_ff    <= side_last.bad;
         fin_use_ff    <= use_mult_in;
         fin_direct_ff <= direct_in;
         fin_prod_ff   <= MULT_W'(base_in) * MULT_W'(fade_q);
      end
   end

   // round the faded product back to q1.15
   logic [MULT_W-1:0] rounded;
   logic [GAIN_W-1:0] fin_gain;

   assign rounded  = fin_prod_ff + MULT_W'(16384);
   assign fin_gain = fin_use_ff ? rounded[GAIN_W+Q_BITS-1:Q_BITS] : fin_direct_ff;

   // output register with a skid stage behind it
   logic              push;
   logic              out_free;
   logic              out_valid_ff;
   logic [GAIN_W-1:0] out_gain_ff;
   logic              out_bad_ff;
   logic [GAIN_W-1:0] skid_gain_ff;
   logic              skid_bad_ff;

   assign push     = en && fin_valid_ff;
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_gain_ff <= skid_gain_ff;
            out_bad_ff  <= skid_bad_ff;
         end else begin
            out_gain_ff <= fin_gain;
            out_bad_ff  <= fin_bad_ff;
         end
      end else if (push) begin
         skid_gain_ff <= fin_gain;
         skid_bad_ff  <= fin_bad_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_bad_ff, out_gain_ff};

endmodule

FILE: hdl/dag_check.sv
// ----------------------------------------------------------------------------
// dag_check
// Port-level checks for the distance attenuation gain block, bound to the
// top level.
// ----------------------------------------------------------------------------
module dag_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dag_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import dag_pkg::*;

   // a bad range always reports unity gain
   a_bad_unity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[GAIN_W] |-> rsp_tdata[GAIN_W-1:0] == ONE_Q15)
      else $error("bad_config result without unity gain");

   // gain never exceeds 1.0
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[GAIN_W-1:0] <= ONE_Q15)
      else $error("gain above 1.0");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // input back-pressure only while a result waits at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind distance_attenuation_gain dag_check u_dag_check (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the distance attenuation gain pipeline. Directed
// table then bursty random distances over several register settings, every
// result checked in order against a fixed expectation or a bit-accurate gain predictor.
// ----------------------------------------------------------------------------
module testbench;
   import dag_pkg::*;

   localparam int PIPE_LAT    = 21;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 1800;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic              bad;
   } gain_result_type;

   typedef struct {
      logic [DIST_WIDTH-1:0] dist_val;
      logic                  known;
      gain_result_type       res;
   } dist_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_REF_DISTANCE;
   logic [DIST_WIDTH-1:0] csr_wdata = '0;

   // predictor copy of the registers and tables
   logic [DIST_WIDTH-1:0] cfg_ref, cfg_max;
   logic [ROLL_W-1:0]     cfg_roll;
   curve_type             cfg_curve;
   logic [15:0]           mant_log [LOG_TABLE_DEPTH];
   logic [31:0]           pow_tab [LOG_TABLE_DEPTH];

   gain_result_type pending_gains[$];
   int  n_errors = 0;
   int  cycles = 0;
   bit  hold_off = 1'b0;
   bit  hold_go = 1'b0;
   bit  stall_pattern = 1'b1;

   distance_attenuation_gain u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [31:0] sq_log(input logic [63:0] zi);
      logic [63:0] z;
      logic [31:0] acc;
      z = zi;
      acc = 0;
      if (z >= (64'd1 << 31)) return 32'd65536;
      for (int i = 15; i >= 0; i--) begin
         z = (z * z) >> 30;
         if (z >= (64'd1 << 31)) begin
            z = z >> 1;
            acc[i] = 1'b1;
         end
      end
      return acc;
   endfunction

   task automatic make_tables();
      logic [63:0] lo, hi, mid, lim;
      for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
         mant_log[k] = 16'(sq_log(((64'(LOG_TABLE_DEPTH) + k) << 30) / LOG_TABLE_DEPTH));
         lo = 64'd1 << 29;
         hi = 64'd1 << 30;
         lim = (64'(LOG_TABLE_DEPTH) - k) * 64'd65536;
         while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            if (64'(sq_log(mid << 1)) * LOG_TABLE_DEPTH <= lim) lo = mid;
            else hi = mid - 1;
         end
         pow_tab[k] = lo[31:0];
      end
   endtask

   function automatic logic [63:0] dist_log2(input logic [63:0] x);
      int e;
      logic [63:0] f;
      e = 0;
      for (int i = 0; i < DIST_WIDTH; i++) if (x[i]) e = i;
      f = (x << (31 - e)) & 64'h7FFF_FFFF;
      f = (f * LOG_TABLE_DEPTH) >> 31;
      if (f >= LOG_TABLE_DEPTH) f = LOG_TABLE_DEPTH - 1;
      return (64'(e) << 16) + mant_log[f];
   endfunction

   function automatic gain_result_type predict_gain(input logic [DIST_WIDTH-1:0] dist_val);
      logic [63:0] rr, mm, ro, d, fade, g, att, den, t, n, idx, base, s;
      gain_result_type res;
      rr = cfg_ref;
      mm = cfg_max;
      ro = cfg_roll;
      d = dist_val;
      res.bad = 1'b0;
      if (rr > mm) begin
         res.gain = ONE_Q15;
         res.bad = 1'b1;
         return res;
      end
      if (d < rr) d = rr;
      if (d > mm) d = mm;
      if (mm == 0) fade = 32768;
      else begin
         fade = ((64'd10 * (mm - d)) << 15) / mm;
         if (fade > 32768) fade = 32768;
      end
      case (cfg_curve)
         CURVE_LINEAR: begin
            if (mm == rr) g = 32768;
            else begin
               att = (ro * (d - rr) * 128) / (mm - rr);
               if (att > 32768) att = 32768;
               g = 32768 - att;
            end
         end
         CURVE_INVERSE: begin
            den = (rr << 8) + ro * (d - rr);
            if (den == 0) g = 32768;
            else g = ((((rr << 23) / den) * fade) + 16384) >> 15;
         end
         CURVE_EXPONENTIAL: begin
            if (d == rr) g = (32768 * fade + 16384) >> 15;
            else if (rr == 0) g = 0;
            else begin
               t = (ro * (dist_log2(d) - dist_log2(rr))) >> 8;
               n = t >> 16;
               idx = ((t & 64'hFFFF) * LOG_TABLE_DEPTH) >> 16;
               if (idx >= LOG_TABLE_DEPTH) idx = LOG_TABLE_DEPTH - 1;
               if (n >= 30) base = 0;
               else begin
                  s = n + 15;
                  base = (64'(pow_tab[idx]) + (64'd1 << (s - 1))) >> s;
               end
               g = (base * fade + 16384) >> 15;
            end
         end
         default: g = 32768;
      endcase
      res.gain = g[15:0];
      return res;
   endfunction

   // one register write; the caller drops the write enable afterwards
   task automatic write_reg(input csr_index_type idx, input logic [DIST_WIDTH-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_REF_DISTANCE: cfg_ref = val;
         CSR_MAX_DISTANCE: cfg_max = val;
         CSR_ROLLOFF:      cfg_roll = val[ROLL_W-1:0];
         default:          cfg_curve = curve_type'(val[1:0]);
      endcase
   endtask

   task automatic apply_setting(input logic [DIST_WIDTH-1:0] r, input logic [DIST_WIDTH-1:0] m,
                                input logic [ROLL_W-1:0] ro, input curve_type c);
      write_reg(CSR_REF_DISTANCE, r);
      write_reg(CSR_MAX_DISTANCE, m);
      write_reg(CSR_ROLLOFF, ro);
      write_reg(CSR_CURVE_MODE, DIST_WIDTH'(c));
      csr_wr_en <= 1'b0;
   endtask

   // wait until the pipe has drained
   task automatic drain();
      while (pending_gains.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   // one request transaction, held until accepted
   task automatic send_dist(input logic [DIST_WIDTH-1:0] dist_val, input bit known,
                            input gain_result_type res);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(dist_val);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_gains.push_back(known ? res : predict_gain(dist_val));
   endtask

   task automatic idle_cycles(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [DIST_WIDTH-1:0] rand_dist();
      case ($urandom_range(0, 5))
         0: return DIST_WIDTH'($urandom);
         1: return DIST_WIDTH'(cfg_ref + DIST_WIDTH'($urandom_range(0, 3)) - 2);
         2: return DIST_WIDTH'(cfg_max + DIST_WIDTH'($urandom_range(0, 3)) - 2);
         default: return (cfg_max > cfg_ref) ?
            cfg_ref + DIST_WIDTH'($urandom_range(0, cfg_max - cfg_ref)) : DIST_WIDTH'($urandom);
      endcase
   endfunction

   task automatic random_phase(input int count);
      int left;
      left = count;
      while (left > 0) begin
         for (int b = $urandom_range(1, 24); b > 0 && left > 0; b--) begin
            send_dist(rand_dist(), 1'b0, '0);
            left--;
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      end
      idle_cycles(1);
   endtask

   // receiver stall pattern with an occasional long hold-off
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else if (stall_pattern) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= 1'b1;
   end

   initial begin
      hold_off = 1'b0;
      @(negedge reset);
      // one long hold-off while the sender keeps offering
      wait (hold_go);
      hold_off = 1'b1;
      repeat (100) @(posedge clock);
      hold_off = 1'b0;
      forever begin
         repeat ($urandom_range(200, 900)) @(posedge clock);
         stall_pattern = ~stall_pattern;
         if ($urandom_range(0, 2) == 0) begin
            hold_off = 1'b1;
            repeat ($urandom_range(60, 120)) @(posedge clock);
            hold_off = 1'b0;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      gain_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_gains.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            n_errors++;
         end else begin
            want = pending_gains.pop_front();
            if (rsp_tdata[15:0] !== want.gain) begin
               $error("proximity_gain expected %0d actual %0d", want.gain, rsp_tdata[15:0]);
               n_errors++;
            end
            if (rsp_tdata[16] !== want.bad) begin
               $error("bad_config expected %0d actual %0d", want.bad, rsp_tdata[16]);
               n_errors++;
            end
         end
      end
   end

   initial begin
      dist_row_type rows[$];
      int t;
      make_tables();
      cfg_ref = 25600;
      cfg_max = 25600;
      cfg_roll = 256;
      cfg_curve = CURVE_LINEAR;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset defaults, zero span linear gives unity
      rows.push_back('{24'd0,        1'b1, '{16'd32768, 1'b0}});
      rows.push_back('{24'hFFFFFF,   1'b1, '{16'd32768, 1'b0}});
      rows.push_back('{24'd25600,    1'b1, '{16'd32768, 1'b0}});
      foreach (rows[i]) send_dist(rows[i].dist_val, rows[i].known, rows[i].res);
      idle_cycles(1);
      drain();

      // reference beyond maximum, every curve
      for (int c = 0; c < 4; c++) begin
         apply_setting(24'd5000, 24'd4999, 16'd256, curve_type'(c));
         send_dist(24'd0, 1'b1, '{16'd32768, 1'b1});
         send_dist(24'hFFFFFF, 1'b1, '{16'd32768, 1'b1});
         idle_cycles(1);
         drain();
      end

      // each curve, normal, zero ref, zero max, extreme rolloff
      for (int c = 0; c < 4; c++) begin
         apply_setting(24'd256, 24'd25600, 16'd256, curve_type'(c));
         send_dist(24'd0, 1'b0, '0);
         send_dist(24'd12800, 1'b0, '0);
         send_dist(24'hFFFFFF, 1'b0, '0);
         idle_cycles(1);
         drain();
         apply_setting(24'd0, 24'd1000, 16'hFFFF, curve_type'(c));
         send_dist(24'd0, 1'b0, '0);
         send_dist(24'd1, 1'b0, '0);
         idle_cycles(1);
         drain();
         apply_setting(24'd0, 24'd0, 16'd0, curve_type'(c));
         send_dist(24'd7, 1'b0, '0);
         idle_cycles(1);
         drain();
      end

      // random phases over settings including extremes
      for (int p = 0; p < 12; p++) begin
         case (p)
            0: apply_setting(24'd1, 24'hFFFFFF, 16'd1, CURVE_EXPONENTIAL);
            1: apply_setting(24'd1, 24'hFFFFFF, 16'hFFFF, CURVE_INVERSE);
            2: apply_setting(24'hFFFFFF, 24'hFFFFFF, 16'd256, CURVE_LINEAR);
            default: begin
               t = $urandom_range(1, 16);
               apply_setting(DIST_WIDTH'($urandom) >> t,
                             DIST_WIDTH'($urandom) >> ($urandom_range(0, t)),
                             ROLL_W'($urandom) >> $urandom_range(0, 15),
                             curve_type'($urandom_range(0, 3)));
            end
         endcase
         if (p == 3) hold_go = 1'b1;
         random_phase(N_RANDOM / 12);
         if (p == 5) begin
            // sender pauses until everything is back
            while (pending_gains.size() != 0) @(posedge clock);
         end
         drain();
      end

      t = 0;
      while (pending_gains.size() != 0 && t < 10000) begin
         @(posedge clock);
         t++;
      end
      repeat (PIPE_LAT + 4) @(posedge clock);
      if (n_errors == 0 && pending_gains.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/dag_pkg.sv
hdl/dag_div.sv
hdl/dag_log.sv
hdl/dag_exp.sv
hdl/distance_attenuation_gain.sv
hdl/dag_check.sv
tb/testbench.sv
